// File: hdl/spbc_pkg.sv
// Shared types and constants for the segment and border polyline crossing block.
// Used by every module in this folder; depends on nothing else.
`default_nettype none
package spbc_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W  = 33;
	localparam int OPND_W  = 34;
	localparam int PROD_W  = 68;
	localparam int CROSS_W = 67;
	localparam int MAG_W   = 66;
	localparam int NUM_W   = 100;
	localparam int QUO_W   = 33;
	localparam int CNT_W   = 7;
	localparam int SNAP_W  = 31;
	localparam int EPS_W   = 40;
	localparam int CFG_W   = 40;
	localparam int CIDX_W  = 3;
	localparam int SIDE_W  = 3;
	localparam int OPC_W   = 3;

	localparam logic [CIDX_W-1:0] REG_LEFT_COUNT  = 3'd0;
	localparam logic [CIDX_W-1:0] REG_RIGHT_COUNT = 3'd1;
	localparam logic [CIDX_W-1:0] REG_UP_COUNT    = 3'd2;
	localparam logic [CIDX_W-1:0] REG_DOWN_COUNT  = 3'd3;
	localparam logic [CIDX_W-1:0] REG_SNAP        = 3'd4;
	localparam logic [CIDX_W-1:0] REG_EPSILON     = 3'd5;

	localparam logic [SIDE_W-1:0] SIDE_NONE = 3'd0;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [1:0] BORDER_DOWN = 2'd3;

	localparam logic [CNT_W-1:0]  RESET_COUNT   = 7'd0;
	localparam logic [SNAP_W-1:0] RESET_SNAP    = 31'd268;
	localparam logic [EPS_W-1:0]  RESET_EPSILON = 40'd72057594;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_NEXT   = 9'b000000010,
		ST_READ   = 9'b000000100,
		ST_LOAD   = 9'b000001000,
		ST_CROSS  = 9'b000010000,
		ST_EVAL   = 9'b000100000,
		ST_LERP   = 9'b001000000,
		ST_DRAIN  = 9'b010000000,
		ST_FINISH = 9'b100000000
	} state_t;

	typedef struct packed {
		logic             valid;
		logic             lane_y;
		logic [NUM_W-1:0] rem;
		logic [QUO_W-1:0] quo;
	} div_data_t;

endpackage
`default_nettype wire

// File: hdl/segment_polyline_border_crossing.sv
// Top level of the segment and border polyline crossing block.
// Depends on spbc_pkg, spbc_border_store and spbc_divider.
//
// A transaction is taken when start is high and busy is low. With func low it
// loads one vertex into the border picked by border_sel and gives no result.
// With func high it runs a query for the segment from start to end and gives
// exactly one result: done is high for one cycle with crossed_side, exit_x
// and exit_y. The receiver cannot stall, so done is never held off. Each
// border segment that is examined goes through the shared 34 by 34
// multiplier, which forms the six products of the three cross products in
// turn. A hit then forms the four lerp products, passes through the 33-cell
// divider chain, which settles one quotient bit per cell, and is snapped;
// done rises together with the snapped result. A miss everywhere raises done
// as the last border is left. Configuration writes go through cfg_write,
// cfg_index and cfg_data and take effect at once. Reset returns to idle, sets
// the vertex counts to zero and the thresholds to their defaults; the vertex
// memory is not cleared.
`default_nettype none
module segment_polyline_border_crossing import spbc_pkg::*; #(
	parameter int MAX_VERTICES = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      func,
	input  wire logic [1:0]                border_sel,
	input  wire logic [5:0]                vertex_index,
	input  wire logic signed [COORD_W-1:0] vertex_x,
	input  wire logic signed [COORD_W-1:0] vertex_y,
	input  wire logic signed [COORD_W-1:0] start_x,
	input  wire logic signed [COORD_W-1:0] start_y,
	input  wire logic signed [COORD_W-1:0] end_x,
	input  wire logic signed [COORD_W-1:0] end_y,
	input  wire logic                      cfg_write,
	input  wire logic [CIDX_W-1:0]         cfg_index,
	input  wire logic [CFG_W-1:0]          cfg_data,
	output logic                           done,
	output logic [SIDE_W-1:0]              crossed_side,
	output logic signed [COORD_W-1:0]      exit_x,
	output logic signed [COORD_W-1:0]      exit_y
);

	localparam int DEPTH = 4 * MAX_VERTICES;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(MAX_VERTICES + 1);

	state_t                    state_q;
	logic [CNT_W-1:0]          count_q [4];
	logic [SNAP_W-1:0]         snap_q;
	logic [EPS_W-1:0]          eps_q;
	logic [1:0]                border_q;
	logic [IW-1:0]             idx_q;
	logic [OPC_W-1:0]          op_q;
	logic [AW-1:0]             rd_addr_q;
	logic signed [COORD_W-1:0] ax_q, ay_q;
	logic signed [DIFF_W-1:0]  ba_x_q, ba_y_q;
	logic signed [DIFF_W-1:0]  ac_x_q, ac_y_q, dc_x_q, dc_y_q;
	logic                      in_box_q;
	logic signed [PROD_W-1:0]  prod_q, hold_q;
	logic signed [CROSS_W-1:0] cross_a_q, det_q, ns_m_q;
	logic [MAG_W-1:0]          det_mag_q, nt_mag_q;
	logic signed [COORD_W-1:0] xc_q, yc_q;
	logic                      done_q;
	logic [SIDE_W-1:0]         side_q;
	logic signed [COORD_W-1:0] exit_x_q, exit_y_q;

	logic                      load_go, query_go, wr_en;
	logic [AW-1:0]             wr_addr, seg_addr;
	logic [CNT_W-1:0]          cnt_sel;
	logic [IW-1:0]             n_cur;
	logic                      seg_ok;
	logic signed [COORD_W-1:0] cx, cy, dx, dy;
	logic                      in_box;
	logic signed [OPND_W-1:0]  mul_a, mul_b;
	logic [DIFF_W-1:0]         abs_ba_x, abs_ba_y;
	logic signed [CROSS_W-1:0] det_n, nt_n, ns_n;
	logic [CROSS_W-1:0]        abs_cross, abs_det, eps_ext;
	logic                      skip;
	logic [NUM_W-1:0]          num;
	div_data_t                 div_in, div_out;
	logic signed [COORD_W+1:0] coord;
	logic signed [COORD_W-1:0] snap_x, snap_y;

	assign busy     = state_q != ST_IDLE;
	assign load_go  = start && !busy && func == FUNC_LOAD;
	assign query_go = start && !busy && func == FUNC_QUERY;
	assign wr_en    = load_go && 32'(vertex_index) < MAX_VERTICES;
	assign wr_addr  = AW'(border_sel) * AW'(MAX_VERTICES) + AW'(vertex_index);

	assign cnt_sel  = count_q[border_q];
	assign n_cur    = (32'(cnt_sel) > MAX_VERTICES) ? IW'(MAX_VERTICES) : IW'(cnt_sel);
	assign seg_ok   = ((IW+1)'(idx_q) + (IW+1)'(1)) < (IW+1)'(n_cur);
	assign seg_addr = AW'(border_q) * AW'(MAX_VERTICES) + AW'(idx_q);

	spbc_border_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_x   (vertex_x),
		.wr_y   (vertex_y),
		.rd_addr(rd_addr_q),
		.rd_cx  (cx),
		.rd_cy  (cy),
		.rd_dx  (dx),
		.rd_dy  (dy)
	);

	assign in_box = ((cx <= dx) ? (ax_q >= cx && ax_q <= dx) : (ax_q >= dx && ax_q <= cx))
		&& ((cy <= dy) ? (ay_q >= cy && ay_q <= dy) : (ay_q >= dy && ay_q <= cy));

	assign abs_ba_x = ba_x_q[DIFF_W-1] ? DIFF_W'(-ba_x_q) : DIFF_W'(ba_x_q);
	assign abs_ba_y = ba_y_q[DIFF_W-1] ? DIFF_W'(-ba_y_q) : DIFF_W'(ba_y_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_CROSS) begin
			case (op_q)
				3'd0: begin mul_a = OPND_W'(ac_x_q); mul_b = OPND_W'(dc_y_q); end
				3'd1: begin mul_a = OPND_W'(ac_y_q); mul_b = OPND_W'(dc_x_q); end
				3'd2: begin mul_a = OPND_W'(ba_x_q); mul_b = OPND_W'(dc_y_q); end
				3'd3: begin mul_a = OPND_W'(ba_y_q); mul_b = OPND_W'(dc_x_q); end
				3'd4: begin mul_a = OPND_W'(ac_x_q); mul_b = OPND_W'(ba_y_q); end
				3'd5: begin mul_a = OPND_W'(ac_y_q); mul_b = OPND_W'(ba_x_q); end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end else begin
			case (op_q)
				3'd0: begin mul_a = {1'b0, nt_mag_q[32:0]};  mul_b = {1'b0, abs_ba_x}; end
				3'd1: begin mul_a = {1'b0, nt_mag_q[65:33]}; mul_b = {1'b0, abs_ba_x}; end
				3'd2: begin mul_a = {1'b0, nt_mag_q[32:0]};  mul_b = {1'b0, abs_ba_y}; end
				3'd3: begin mul_a = {1'b0, nt_mag_q[65:33]}; mul_b = {1'b0, abs_ba_y}; end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end
	end

	assign det_n     = det_q[CROSS_W-1] ? -det_q : det_q;
	assign nt_n      = det_q[CROSS_W-1] ? cross_a_q : -cross_a_q;
	assign ns_n      = det_q[CROSS_W-1] ? ns_m_q : -ns_m_q;
	assign abs_cross = cross_a_q[CROSS_W-1] ? CROSS_W'(-cross_a_q) : CROSS_W'(cross_a_q);
	assign abs_det   = CROSS_W'(det_n);
	assign eps_ext   = CROSS_W'(eps_q);
	assign skip      = (in_box_q && abs_cross < eps_ext) || abs_det < eps_ext
		|| det_q == '0 || nt_n[CROSS_W-1] || nt_n > det_n
		|| ns_n[CROSS_W-1] || ns_n > det_n;

	assign num = NUM_W'(hold_q[MAG_W-1:0]) + (NUM_W'(prod_q[MAG_W-1:0]) << QUO_W);

	assign div_in.valid  = state_q == ST_LERP && (op_q == 3'd2 || op_q == 3'd4);
	assign div_in.lane_y = op_q == 3'd4;
	assign div_in.rem    = num;
	assign div_in.quo    = '0;

	spbc_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (div_in),
		.divisor(det_mag_q),
		.dout   (div_out)
	);

	always_comb begin
		if (div_out.lane_y ? ba_y_q[DIFF_W-1] : ba_x_q[DIFF_W-1]) begin
			coord = (COORD_W+2)'(div_out.lane_y ? ay_q : ax_q) - $signed({1'b0, div_out.quo});
		end else begin
			coord = (COORD_W+2)'(div_out.lane_y ? ay_q : ax_q) + $signed({1'b0, div_out.quo});
		end
	end

	assign snap_x = (COORD_W'(xc_q[COORD_W-1] ? -xc_q : xc_q) < COORD_W'(snap_q)) ? '0 : xc_q;
	assign snap_y = (COORD_W'(yc_q[COORD_W-1] ? -yc_q : yc_q) < COORD_W'(snap_q)) ? '0 : yc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < 4; b++) begin
				count_q[b] <= RESET_COUNT;
			end
			snap_q <= RESET_SNAP;
			eps_q  <= RESET_EPSILON;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_LEFT_COUNT:  count_q[0] <= cfg_data[CNT_W-1:0];
				REG_RIGHT_COUNT: count_q[1] <= cfg_data[CNT_W-1:0];
				REG_UP_COUNT:    count_q[2] <= cfg_data[CNT_W-1:0];
				REG_DOWN_COUNT:  count_q[3] <= cfg_data[CNT_W-1:0];
				REG_SNAP:        snap_q     <= cfg_data[SNAP_W-1:0];
				REG_EPSILON:     eps_q      <= cfg_data[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			border_q <= '0;
			idx_q    <= '0;
			op_q     <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (query_go) begin
						border_q <= '0;
						idx_q    <= '0;
						state_q  <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (seg_ok) begin
						state_q <= ST_READ;
					end else if (border_q == BORDER_DOWN) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						border_q <= border_q + 2'd1;
						idx_q    <= '0;
					end
				end
				ST_READ: state_q <= ST_LOAD;
				ST_LOAD: begin
					op_q    <= '0;
					state_q <= ST_CROSS;
				end
				ST_CROSS: begin
					op_q <= op_q + OPC_W'(1);
					if (op_q == 3'd6) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					op_q <= '0;
					if (skip) begin
						idx_q   <= idx_q + IW'(1);
						state_q <= ST_NEXT;
					end else begin
						state_q <= ST_LERP;
					end
				end
				ST_LERP: begin
					op_q <= op_q + OPC_W'(1);
					if (op_q == 3'd4) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (div_out.valid && div_out.lane_y) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (query_go) begin
			ax_q   <= start_x;
			ay_q   <= start_y;
			ba_x_q <= DIFF_W'(end_x) - DIFF_W'(start_x);
			ba_y_q <= DIFF_W'(end_y) - DIFF_W'(start_y);
		end
		if (state_q == ST_NEXT) begin
			rd_addr_q <= seg_addr;
			if (!seg_ok && border_q == BORDER_DOWN) begin
				side_q   <= SIDE_NONE;
				exit_x_q <= ax_q;
				exit_y_q <= ay_q;
			end
		end
		if (state_q == ST_LOAD) begin
			ac_x_q   <= DIFF_W'(ax_q) - DIFF_W'(cx);
			ac_y_q   <= DIFF_W'(ay_q) - DIFF_W'(cy);
			dc_x_q   <= DIFF_W'(dx) - DIFF_W'(cx);
			dc_y_q   <= DIFF_W'(dy) - DIFF_W'(cy);
			in_box_q <= in_box;
		end
		if (state_q == ST_CROSS && op_q != 3'd0) begin
			case (op_q)
				3'd2: cross_a_q <= CROSS_W'(hold_q - prod_q);
				3'd4: det_q     <= CROSS_W'(hold_q - prod_q);
				3'd6: ns_m_q    <= CROSS_W'(hold_q - prod_q);
				default: hold_q <= prod_q;
			endcase
		end
		if (state_q == ST_LERP && (op_q == 3'd1 || op_q == 3'd3)) begin
			hold_q <= prod_q;
		end
		if (state_q == ST_EVAL) begin
			det_mag_q <= det_n[MAG_W-1:0];
			nt_mag_q  <= nt_n[MAG_W-1:0];
		end
		if (state_q == ST_DRAIN && div_out.valid) begin
			if (div_out.lane_y) begin
				yc_q <= coord[COORD_W-1:0];
			end else begin
				xc_q <= coord[COORD_W-1:0];
			end
		end
		if (state_q == ST_FINISH) begin
			side_q   <= SIDE_W'(border_q) + SIDE_W'(1);
			exit_x_q <= snap_x;
			exit_y_q <= snap_y;
		end
	end

	assign done         = done_q;
	assign crossed_side = side_q;
	assign exit_x       = exit_x_q;
	assign exit_y       = exit_y_q;

endmodule
`default_nettype wire

// File: hdl/spbc_div_cell.sv
// One cell of the divider chain: settles one quotient bit per transaction.
// Depends on spbc_pkg.
`default_nettype none
module spbc_div_cell import spbc_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_data_t        din,
	input  wire logic [MAG_W-1:0] divisor,
	output div_data_t             dout
);

	logic [NUM_W-1:0] dsh;
	logic             take;

	assign dsh  = NUM_W'(divisor) << SHIFT;
	assign take = din.rem >= dsh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else begin
			dout.valid  <= din.valid;
			dout.lane_y <= din.lane_y;
			dout.rem    <= take ? din.rem - dsh : din.rem;
			dout.quo    <= din.quo | (QUO_W'(take) << SHIFT);
		end
	end

endmodule
`default_nettype wire

// File: hdl/spbc_divider.sv
// Row of divider cells that turns a crossing numerator into the coordinate offset.
// Depends on spbc_pkg and spbc_div_cell.
`default_nettype none
module spbc_divider import spbc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_data_t        din,
	input  wire logic [MAG_W-1:0] divisor,
	output div_data_t             dout
);

	div_data_t link [QUO_W+1];

	assign link[0] = din;

	for (genvar j = 0; j < QUO_W; j++) begin : g_cell
		spbc_div_cell #(
			.SHIFT(QUO_W - 1 - j)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (link[j]),
			.divisor(divisor),
			.dout   (link[j+1])
		);
	end

	assign dout = link[QUO_W];

endmodule
`default_nettype wire

// File: hdl/spbc_border_store.sv
// Vertex memory for the four border polylines, one write port and two read ports.
// Depends on spbc_pkg.
`default_nettype none
module spbc_border_store import spbc_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [COORD_W-1:0]       wr_x,
	input  wire logic [COORD_W-1:0]       wr_y,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [COORD_W-1:0]            rd_cx,
	output logic [COORD_W-1:0]            rd_cy,
	output logic [COORD_W-1:0]            rd_dx,
	output logic [COORD_W-1:0]            rd_dy
);

	localparam int AW = $clog2(DEPTH);

	logic [COORD_W-1:0] mem_x [DEPTH];
	logic [COORD_W-1:0] mem_y [DEPTH];
	logic [AW-1:0]      rd_next;

	assign rd_next = rd_addr + AW'(1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[wr_addr] <= wr_x;
			mem_y[wr_addr] <= wr_y;
		end
	end

	always_ff @(posedge clk) begin
		rd_cx <= mem_x[rd_addr];
		rd_cy <= mem_y[rd_addr];
		rd_dx <= mem_x[rd_next];
		rd_dy <= mem_y[rd_next];
	end

endmodule
`default_nettype wire
